>>> rtl/pva_pkg.sv
`timescale 1ns / 1ps
package pva_pkg;
   typedef enum logic [1:0] {
      CMD_NOTE_DOWN = 2'd0,
      CMD_NOTE_UP   = 2'd1,
      CMD_SUS_DOWN  = 2'd2,
      CMD_SUS_UP    = 2'd3
   } cmd_type;

   localparam logic ACT_TRIGGER = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;
   localparam int   MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0] cmd;
      logic [6:0] note_number;
      logic [6:0] strike_velocity;
   } req_type;

   typedef struct packed {
      logic       action;
      logic [3:0] voice_index;
      logic [6:0] voice_note;
      logic [6:0] voice_velocity;
      logic       stolen;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DOWN,
      ST_RECENCY,
      ST_UP,
      ST_SWEEP,
      ST_EMIT
   } state_type;
endpackage

>>> rtl/pva_if.sv
`timescale 1ns / 1ps
interface pva_req_if;
   logic                valid;
   logic                ready;
   pva_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pva_rsp_if;
   logic                valid;
   logic                ready;
   pva_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/polyphonic_voice_allocator.sv
`timescale 1ns / 1ps
// A note down passes lookup, allocation and the recency walk before its trigger; a note up passes lookup and release.
// Sustain up walks the recency order, one voice a cycle with an extra emit step per release,
// stalling while a release waits on the response port.
// The engine takes one request at a time.
// Reset (synchronous): a clear of all 128 note-map entries runs before the first request.
module polyphonic_voice_allocator #(
   parameter int VOICE_COUNT = 16
) (
   input  logic clock,
   input  logic reset,
   pva_req_if.sink   req,
   pva_rsp_if.source rsp
);
   import pva_pkg::*;

   // request queue between front and engine
   pva_req_if cmdq ();

   pva_front u_front (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .cmdq (cmdq)
   );

   // engine: lookup, allocate, recency walk, sustain sweep
   pva_engine #(.VOICE_COUNT(VOICE_COUNT)) u_engine (
      .clock(clock),
      .reset(reset),
      .cmdq (cmdq),
      .rsp  (rsp)
   );
endmodule

>>> rtl/pva_ram.sv
`timescale 1ns / 1ps
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/pva_front.sv
`timescale 1ns / 1ps
// Input skid: two-entry queue between the request port and the engine.
module pva_front (
   input  logic clock,
   input  logic reset,
   pva_req_if.sink   req,
   pva_req_if.source cmdq
);
   import pva_pkg::*;

   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign req.ready    = (count_ff != 2'd2);
   assign push         = req.valid && req.ready;
   assign pop          = cmdq.valid && cmdq.ready;
   assign cmdq.valid   = (count_ff != 2'd0);
   assign cmdq.payload = slot_ff[0];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (pop) begin
            if (count_ff == 2'd1) slot_in[0] = req.payload;
            else                  slot_in[1] = req.payload;
         end else begin
            if (count_ff == 2'd0) slot_in[0] = req.payload;
            else                  slot_in[1] = req.payload;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end
endmodule

>>> rtl/pva_engine.sv
`timescale 1ns / 1ps
// Allocation engine: one request at a time, sequenced.
module pva_engine #(
   parameter int VOICE_COUNT = 16
) (
   input  logic clock,
   input  logic reset,
   pva_req_if.sink   cmdq,
   pva_rsp_if.source rsp
);
   import pva_pkg::*;

   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int MW = $clog2(VOICE_COUNT + 1);
   localparam int CW = $clog2(VOICE_COUNT + 1);
   localparam int EW = $clog2(MAX_RESULTS + 1);
   localparam logic [VW-1:0] VLAST = VW'(VOICE_COUNT - 1);
   localparam logic [CW-1:0] NV    = CW'(VOICE_COUNT);

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;

   // note map: 128 x (voice+1), cleared by a sweep after reset
   logic          map_we;
   logic [6:0]    map_wa;
   logic [MW-1:0] map_wd;
   logic [6:0]    map_ra;
   logic [MW-1:0] map_rd;
   logic          clearing_ff;
   logic [6:0]    clr_ff;

   pva_ram #(.WIDTH(MW), .DEPTH(128)) u_map (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_wa),
      .wr_data(map_wd),
      .rd_addr(map_ra),
      .rd_data(map_rd)
   );

   logic [6:0]    vnote_ff  [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] held_ff, play_ff, sus_ff;
   logic [VW-1:0] rec_ff   [VOICE_COUNT];
   logic [VW-1:0] fifo_ff  [VOICE_COUNT];
   logic [VW-1:0] head_ff;
   logic [CW-1:0] fcount_ff;

   logic [VW-1:0] v_ff;
   logic          stl_ff;
   logic [VW-1:0] pos_ff;     // recency walk pointer / sweep index
   logic          found_ff;
   logic [EW-1:0] emitted_ff; // saturates at the result cap
   logic          ret_sweep_ff; // emit returns to sweep
   logic [VW-1:0] order_ff [VOICE_COUNT];
   rsp_type       out_ff;
   logic          out_valid_ff;

   logic [VW-1:0] tail_idx;
   logic [VW:0]   tail_sum;
   logic [VW-1:0] sv;
   logic          sweep_end;
   logic          later_rel;

   // only used while fcount_ff < VOICE_COUNT, so the count fits VW bits
   assign tail_sum = {1'b0, head_ff} + {1'b0, VW'(fcount_ff)};
   assign tail_idx = (tail_sum >= (VW+1)'(VOICE_COUNT)) ?
                     VW'(tail_sum - (VW+1)'(VOICE_COUNT)) : tail_sum[VW-1:0];
   assign sv       = order_ff[pos_ff];
   assign sweep_end = (pos_ff == VLAST);

   assign cmdq.ready  = (state_ff == ST_IDLE) && !clearing_ff && !out_valid_ff;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   // any voice later in the sweep that will release as well
   always_comb begin
      later_rel = 1'b0;
      for (int j = 0; j < VOICE_COUNT; j++) begin
         if (VW'(j) > pos_ff && sus_ff[order_ff[j]] &&
             play_ff[order_ff[j]] && !held_ff[order_ff[j]])
            later_rel = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (cmdq.valid && cmdq.ready) begin
                         state_in = (cmdq.payload.cmd == CMD_SUS_DOWN) ? ST_IDLE :
                                    (cmdq.payload.cmd == CMD_SUS_UP)   ? ST_SWEEP :
                                    ST_LOOKUP;
                      end
         ST_LOOKUP:   state_in = (cur_ff.cmd == CMD_NOTE_DOWN) ? ST_DOWN : ST_UP;
         ST_DOWN:     state_in = ST_RECENCY;
         ST_RECENCY:  if (sweep_end) state_in = ST_EMIT;
         ST_UP:       state_in = ST_IDLE;
         ST_SWEEP:    if (!out_valid_ff || rsp.ready) begin
                         if (sus_ff[sv] && play_ff[sv] && !held_ff[sv])
                            state_in = ST_EMIT;
                         else if (sweep_end)
                            state_in = ST_IDLE;
                      end
         ST_EMIT:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
      if (state_ff == ST_EMIT && ret_sweep_ff && !sweep_end) state_in = ST_SWEEP;
   end

   always_comb begin
      cur_in = cur_ff;
      if (state_ff == ST_IDLE && cmdq.valid && cmdq.ready) cur_in = cmdq.payload;
   end

   // map port control
   always_comb begin
      map_ra = cur_in.note_number;
      map_we = 1'b0;
      map_wa = cur_ff.note_number;
      map_wd = '0;
      if (clearing_ff) begin
         map_we = 1'b1;
         map_wa = clr_ff;
      end else if (state_ff == ST_DOWN && stl_ff) begin
         // dropped old mapping cleared in the ST_DOWN case below
         map_we = 1'b0;
      end
      if (!clearing_ff) begin
         case (state_ff)
            ST_LOOKUP: begin
               map_ra = vnote_ff[rec_ff[0]];
            end
            ST_DOWN: begin
               if (stl_ff && map_rd == MW'({1'b0, v_ff} + 1)) begin
                  map_we = 1'b1;
                  map_wa = vnote_ff[v_ff];
               end
            end
            ST_RECENCY: if (sweep_end) begin
               map_we = 1'b1;
               map_wa = cur_ff.note_number;
               map_wd = MW'({1'b0, v_ff} + 1);
            end
            ST_UP: if (found_ff && held_ff[v_ff] && play_ff[v_ff] && !sus_ff[v_ff]) begin
               map_we = 1'b1;
               map_wa = vnote_ff[v_ff];
            end
            ST_SWEEP: if ((!out_valid_ff || rsp.ready) &&
                          sus_ff[sv] && play_ff[sv] && !held_ff[sv]) begin
               map_we = 1'b1;
               map_wa = vnote_ff[sv];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         held_ff      <= '0;
         play_ff      <= '0;
         sus_ff       <= '0;
         head_ff      <= '0;
         fcount_ff    <= NV;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            rec_ff[i]   <= VW'(i);
            fifo_ff[i]  <= VW'(i);
            vnote_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (clearing_ff) begin
            clr_ff <= clr_ff + 7'd1;
            if (clr_ff == 7'd127) clearing_ff <= 1'b0;
         end
         if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (cmdq.valid && cmdq.ready) begin
               emitted_ff   <= '0;
               pos_ff       <= '0;
               found_ff     <= 1'b0;
               ret_sweep_ff <= 1'b0;
               order_ff     <= rec_ff;
               if (cmdq.payload.cmd == CMD_SUS_DOWN) sus_ff <= '1;
            end
            ST_LOOKUP: ;
            ST_DOWN: begin
               found_ff <= 1'b0;
               pos_ff   <= '0;
            end
            ST_RECENCY: begin
               // shift one entry per cycle once the voice is passed
               if (found_ff || rec_ff[pos_ff] == v_ff) begin
                  if (!sweep_end) rec_ff[pos_ff] <= rec_ff[pos_ff + VW'(1)];
                  found_ff <= 1'b1;
               end
               if (sweep_end) begin
                  rec_ff[pos_ff]  <= v_ff;
                  held_ff[v_ff]   <= 1'b1;
                  play_ff[v_ff]   <= 1'b1;
                  vnote_ff[v_ff]  <= cur_ff.note_number;
                  out_ff.action         <= ACT_TRIGGER;
                  out_ff.voice_index    <= 4'(v_ff);
                  out_ff.voice_note     <= cur_ff.note_number;
                  out_ff.voice_velocity <= cur_ff.strike_velocity;
                  out_ff.stolen         <= stl_ff;
                  out_ff.last           <= 1'b1;
               end else begin
                  pos_ff <= pos_ff + VW'(1);
               end
            end
            ST_UP: if (found_ff && held_ff[v_ff]) begin
               held_ff[v_ff] <= 1'b0;
               if (play_ff[v_ff] && !sus_ff[v_ff]) begin
                  play_ff[v_ff]  <= 1'b0;
                  vnote_ff[v_ff] <= '0;
                  if (fcount_ff < NV) begin
                     fifo_ff[tail_idx] <= v_ff;
                     fcount_ff         <= fcount_ff + CW'(1);
                  end
                  out_ff.action         <= ACT_RELEASE;
                  out_ff.voice_index    <= 4'(v_ff);
                  out_ff.voice_note     <= vnote_ff[v_ff];
                  out_ff.voice_velocity <= '0;
                  out_ff.stolen         <= 1'b0;
                  out_ff.last           <= 1'b1;
                  out_valid_ff          <= 1'b1;
               end
            end
            ST_SWEEP: if (!out_valid_ff || rsp.ready) begin
               if (sus_ff[sv]) begin
                  sus_ff[sv] <= 1'b0;
                  if (play_ff[sv] && !held_ff[sv]) begin
                     play_ff[sv]  <= 1'b0;
                     vnote_ff[sv] <= '0;
                     if (fcount_ff < NV) begin
                        fifo_ff[tail_idx] <= sv;
                        fcount_ff         <= fcount_ff + CW'(1);
                     end
                     ret_sweep_ff          <= 1'b1;
                     out_ff.action         <= ACT_RELEASE;
                     out_ff.voice_index    <= 4'(sv);
                     out_ff.voice_note     <= vnote_ff[sv];
                     out_ff.voice_velocity <= '0;
                     out_ff.stolen         <= 1'b0;
                     out_ff.last           <= 1'b0;
                  end
               end
               if (!(sus_ff[sv] && play_ff[sv] && !held_ff[sv])) begin
                  if (!sweep_end) pos_ff <= pos_ff + VW'(1);
               end
            end
            ST_EMIT: begin
               // output register is free here (sweep waited for it)
               if (ret_sweep_ff) begin
                  // last if no later voice releases; the final result that
                  // fits under the cap closes the run when more would follow
                  out_ff.last  <= (emitted_ff == EW'(MAX_RESULTS - 1)) || !later_rel;
                  out_valid_ff <= (emitted_ff < EW'(MAX_RESULTS));
                  if (emitted_ff < EW'(MAX_RESULTS)) emitted_ff <= emitted_ff + EW'(1);
                  if (!sweep_end) pos_ff <= pos_ff + VW'(1);
               end else begin
                  out_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
         if (state_ff == ST_LOOKUP) begin
            // map_rd holds the mapping of the request note
            if (map_rd != '0 && map_rd <= MW'(VOICE_COUNT)) begin
               v_ff     <= VW'(map_rd - MW'(1));
               stl_ff   <= 1'b0;
               found_ff <= 1'b1;
            end else if (cur_ff.cmd == CMD_NOTE_DOWN) begin
               if (fcount_ff == '0) begin
                  v_ff   <= rec_ff[0];
                  stl_ff <= 1'b1;
               end else begin
                  v_ff      <= fifo_ff[head_ff];
                  stl_ff    <= 1'b0;
                  head_ff   <= (head_ff == VLAST) ? '0 : head_ff + VW'(1);
                  fcount_ff <= fcount_ff - CW'(1);
               end
            end
         end
      end
      cur_ff <= cur_in;
   end
endmodule

>>> rtl/pva_checker.sv
`timescale 1ns / 1ps
module pva_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input pva_pkg::rsp_type rsp_payload
);
   import pva_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped while stalled");

   a_rel_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.action == ACT_RELEASE |->
      rsp_payload.voice_velocity == 7'd0 && !rsp_payload.stolen)
      else $error("release with velocity or steal flag");

   a_trig_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.action == ACT_TRIGGER |-> rsp_payload.last)
      else $error("trigger not last");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("queue not empty after reset");
endmodule

bind polyphonic_voice_allocator pva_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_payload(rsp.payload)
);
